>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Default sizes
    localparam int unsigned CAPACITY_DEF      = 128;
    localparam int unsigned PRIORITY_BITS_DEF = 8;
    localparam int unsigned PAYLOAD_BITS_DEF  = 32;

    // Request codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_in;   // insert a new entry at its sorted place
        logic shift_out;  // drop the head, move all entries one place up
    } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEF
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic                     occupied,
    input  logic [PRIORITY_BITS-1:0] new_priority,
    input  logic [PAYLOAD_BITS-1:0]  new_payload,
    input  logic                     left_take,
    input  logic [PRIORITY_BITS-1:0] left_priority,
    input  logic [PAYLOAD_BITS-1:0]  left_payload,
    input  logic [PRIORITY_BITS-1:0] right_priority,
    input  logic [PAYLOAD_BITS-1:0]  right_payload,
    output logic                     take,
    output logic [PRIORITY_BITS-1:0] cell_priority,
    output logic [PAYLOAD_BITS-1:0]  cell_payload
);

    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [PRIORITY_BITS-1:0] pri_next;
    logic [PAYLOAD_BITS-1:0]  pay_reg;
    logic [PAYLOAD_BITS-1:0]  pay_next;

    // Yield this slot when it is empty or holds a strictly lower priority
    assign take = !occupied || (pri_reg < new_priority);

    // Pick the next content: hold, take from the left, take the new entry, or advance
    always_comb
    begin
        pri_next = pri_reg;
        pay_next = pay_reg;
        if (ctrl.shift_in && take)
        begin
            if (left_take)
            begin
                pri_next = left_priority;
                pay_next = left_payload;
            end
            else
            begin
                pri_next = new_priority;
                pay_next = new_payload;
            end
        end
        else if (ctrl.shift_out)
        begin
            pri_next = right_priority;
            pay_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        pay_reg <= pay_next;
    end

    assign cell_priority = pri_reg;
    assign cell_payload  = pay_reg;

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// A result is registered and appears in the cycle after its request beat is accepted.
// Throughput: one insert or remove per cycle unless a stalled result holds in_ready
// low; each cell compares and shifts in the same cycle, so the chain never iterates.
// Reset: rst_n clears the entry count and the output valid flag; cell contents
// are left as they are and are never read until written.
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY      = CAPACITY_DEF,
    parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
    localparam int unsigned CW           = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    input  logic [PAYLOAD_BITS-1:0]  payload,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [PAYLOAD_BITS-1:0]  served_payload,
    output logic [PRIORITY_BITS-1:0] served_priority,
    output logic [CW-1:0]            occupancy
);

    logic                     fire;
    logic                     is_insert;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [PAYLOAD_BITS-1:0]  pay_out_reg;
    logic [PAYLOAD_BITS-1:0]  pay_out_next;
    logic [PRIORITY_BITS-1:0] pri_out_reg;
    logic [PRIORITY_BITS-1:0] pri_out_next;

    logic                     take_w [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_w  [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  pay_w  [CAPACITY];

    // Accept a beat whenever the output register is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign is_insert = (mode == MODE_INSERT);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign ctrl.shift_in  = fire && is_insert && !full;
    assign ctrl.shift_out = fire && !is_insert && !empty;

    // Cell chain: slot 0 holds the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     occ;
        logic                     lt;
        logic [PRIORITY_BITS-1:0] lp;
        logic [PAYLOAD_BITS-1:0]  ld;
        logic [PRIORITY_BITS-1:0] rp;
        logic [PAYLOAD_BITS-1:0]  rd;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign lt = 1'b0;
            assign lp = '0;
            assign ld = '0;
        end
        else
        begin : g_mid
            assign lt = take_w[i-1];
            assign lp = pri_w[i-1];
            assign ld = pay_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rp = pri_w[i];
            assign rd = pay_w[i];
        end
        else
        begin : g_inner
            assign rp = pri_w[i+1];
            assign rd = pay_w[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS)
        ) u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .occupied       (occ),
            .new_priority   (priority_req),
            .new_payload    (payload),
            .left_take      (lt),
            .left_priority  (lp),
            .left_payload   (ld),
            .right_priority (rp),
            .right_payload  (rd),
            .take           (take_w[i]),
            .cell_priority  (pri_w[i]),
            .cell_payload   (pay_w[i])
        );
    end

    // Build the result of the accepted beat
    always_comb
    begin
        count_next   = count_reg;
        pay_out_next = '0;
        pri_out_next = '0;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next  = ST_SERVED;
                count_next   = count_reg - CW'(1);
                pay_out_next = pay_w[0];
                pri_out_next = pri_w[0];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg  <= status_next;
            pay_out_reg <= pay_out_next;
            pri_out_reg <= pri_out_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign served_payload  = pay_out_reg;
    assign served_priority = pri_out_reg;
    assign occupancy       = count_reg;

endmodule

>>> rtl/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY      = CAPACITY_DEF,
    parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
    localparam int unsigned CW           = $clog2(CAPACITY + 1)
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     mode,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               status,
    input logic [PAYLOAD_BITS-1:0]  served_payload,
    input logic [PRIORITY_BITS-1:0] served_priority,
    input logic [CW-1:0]            occupancy
);

    // A rejected insert only happens at full capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == CW'(CAPACITY)))
        else $error("full status with queue not at capacity");

    // An empty report leaves nothing stored
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with entries stored");

    // Served fields are zero unless an entry was served
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_SERVED) |-> (served_payload == '0 && served_priority == '0))
        else $error("served fields nonzero without a served entry");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(occupancy)))
        else $error("result beat changed while stalled");

    // An accepted insert beat yields an insert or full result
    a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_INSERT) |=>
            (out_valid && (status == ST_INSERTED || status == ST_FULL)))
        else $error("insert beat without an insert result");

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_spq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .served_payload  (served_payload),
    .served_priority (served_priority),
    .occupancy       (occupancy)
);

>>> tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int unsigned CAP          = CAPACITY_DEF;
    localparam int unsigned PRI_W        = PRIORITY_BITS_DEF;
    localparam int unsigned TAG_W        = PAYLOAD_BITS_DEF;
    localparam int unsigned CW           = $clog2(CAP + 1);
    localparam int unsigned LIMIT_CYCLES = 300000;

    typedef struct {
        logic             mode;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } request_t;

    typedef struct {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        logic [CW-1:0]    occ;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             mode;
    logic [PRI_W-1:0] priority_req;
    logic [TAG_W-1:0] payload;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [TAG_W-1:0] served_payload;
    logic [PRI_W-1:0] served_priority;
    logic [CW-1:0]    occupancy;

    // Requests waiting to be driven, and results waiting to come out
    request_t         request_queue[$];
    result_t          pending_results[$];

    // Shadow copy of the stored entries, head at index 0
    logic [PRI_W-1:0] sorted_pri[$];
    logic [TAG_W-1:0] sorted_tag[$];

    int unsigned      cycle_count;
    int unsigned      accepted_count;
    int unsigned      request_total;
    int unsigned      error_count;
    int unsigned      idle_left;
    int unsigned      stall_left;
    int unsigned      gap;
    logic             in_taken;
    request_t         next_req;
    result_t          want;

    sorted_priority_queue DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .priority_req    (priority_req),
        .payload         (payload),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .served_payload  (served_payload),
        .served_priority (served_priority),
        .occupancy       (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one request to the shadow queue and return the result it causes
    function automatic result_t apply_request(request_t req);
        result_t res;
        int      pos;
        res.status = ST_INSERTED;
        res.tag    = '0;
        res.pri    = '0;
        if (req.mode == MODE_INSERT)
        begin
            if (sorted_pri.size() >= CAP)
                res.status = ST_FULL;
            else
            begin
                // Place after every entry of equal or higher priority
                pos = sorted_pri.size();
                while (pos > 0 && sorted_pri[pos-1] < req.pri)
                    pos--;
                sorted_pri.insert(pos, req.pri);
                sorted_tag.insert(pos, req.tag);
            end
        end
        else if (sorted_pri.size() == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.status = ST_SERVED;
            res.pri    = sorted_pri.pop_front();
            res.tag    = sorted_tag.pop_front();
        end
        res.occ = CW'(sorted_pri.size());
        return res;
    endfunction

    // Idle length: mostly none or short, a few long, none at all in quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (((cycle_count / 400) % 5) == 2)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_request(logic m, logic [PRI_W-1:0] p, logic [TAG_W-1:0] t);
        request_t req;
        req.mode = m;
        req.pri  = p;
        req.tag  = t;
        request_queue.push_back(req);
    endtask

    task automatic check_field(string fname, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s expected %0h got %0h", $time, fname, expected, actual);
            error_count++;
        end
    endtask

    // Build the directed and random request lists
    task automatic build_requests();
        int unsigned      ins_pct;
        int unsigned      seg_len;
        int unsigned      r;
        logic [PRI_W-1:0] p;
        logic [TAG_W-1:0] t;
        // Remove from empty, extremes, ties in arrival order
        add_request(MODE_REMOVE, 8'd0, 32'd0);
        add_request(MODE_INSERT, 8'd0, 32'h0000_0000);
        add_request(MODE_INSERT, 8'd255, 32'hFFFF_FFFF);
        add_request(MODE_INSERT, 8'd128, 32'h0000_0001);
        add_request(MODE_INSERT, 8'd128, 32'h0000_0002);
        add_request(MODE_INSERT, 8'd128, 32'h0000_0003);
        add_request(MODE_INSERT, 8'd255, 32'hA5A5_A5A5);
        add_request(MODE_INSERT, 8'd0, 32'h5A5A_5A5A);
        // Fields on a remove carry no meaning
        add_request(MODE_REMOVE, 8'd255, 32'hFFFF_FFFF);
        repeat (6)
            add_request(MODE_REMOVE, 8'd0, 32'd0);
        add_request(MODE_REMOVE, 8'h5A, 32'h1234_5678);
        add_request(MODE_INSERT, 8'd1, 32'h8000_0000);
        add_request(MODE_INSERT, 8'd254, 32'h7FFF_FFFF);
        add_request(MODE_REMOVE, 8'd0, 32'd0);
        add_request(MODE_REMOVE, 8'd0, 32'd0);

        // Fill past full, drain past empty, then mix
        for (int seg = 0; seg < 4; seg++)
        begin
            case (seg)
                0: begin ins_pct = 90; seg_len = 230; end
                1: begin ins_pct = 10; seg_len = 200; end
                2: begin ins_pct = 50; seg_len = 150; end
                default: begin ins_pct = 80; seg_len = 170; end
            endcase
            for (int i = 0; i < seg_len; i++)
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    p = PRI_W'($urandom_range(0, 3));
                else if (r == 1)
                    p = ($urandom_range(0, 1) != 0) ? '1 : '0;
                else
                    p = PRI_W'($urandom);
                r = $urandom_range(0, 19);
                if (r == 0)
                    t = '0;
                else if (r == 1)
                    t = '1;
                else
                    t = TAG_W'($urandom);
                add_request(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE,
                            p, t);
            end
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_INSERT;
        priority_req = '0;
        payload      = '0;
        out_ready    = 1'b0;
        build_requests();
        request_total = request_queue.size();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (accepted_count < request_total)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (error_count == 0)
            $display("sorted_priority_queue: match");
        else
            $display("sorted_priority_queue: mismatch");
        $finish;
    end

    // Driver: offer the next request, hold it until accepted
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    next_req = request_queue.pop_front();
                    mode         <= next_req.mode;
                    priority_req <= next_req.pri;
                    payload      <= next_req.tag;
                    in_valid     <= 1'b1;
                    idle_left    = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end

            // Stall the result side at random
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    out_ready <= 1'b1;
                else
                begin
                    stall_left = gap - 1;
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Monitor: check result beats, then predict from request beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("%0t: run timed out", $time);
                $display("sorted_priority_queue: mismatch");
                $finish;
            end

            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, status %0d occupancy %0d",
                             $time, status, occupancy);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("served_payload", 32'(want.tag), 32'(served_payload));
                    check_field("served_priority", 32'(want.pri), 32'(served_priority));
                    check_field("occupancy", 32'(want.occ), 32'(occupancy));
                end
            end

            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                next_req.mode = mode;
                next_req.pri  = priority_req;
                next_req.tag  = payload;
                pending_results.push_back(apply_request(next_req));
                accepted_count++;
            end
        end
    end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/sorted_priority_queue_tb.sv
